@@ rtl/sparse_polynomial_multiply_unit_macros.svh @@
// Assertion macros for the sparse polynomial multiply unit.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef SPARSE_POLYNOMIAL_MULTIPLY_UNIT_MACROS_SVH
`define SPARSE_POLYNOMIAL_MULTIPLY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// expr must hold at every clock edge out of reset
`define SPM_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error("lbl");
// a in one cycle implies b in the same cycle
`define SPM_ASSERT_IMPLY(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error("lbl");
// a in one cycle implies b in the next
`define SPM_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error("lbl");
`else
`define SPM_ASSERT_ALWAYS(lbl, expr)
`define SPM_ASSERT_IMPLY(lbl, a, b)
`define SPM_ASSERT_NEXT(lbl, a, b)
`endif
`endif

@@ rtl/spm_pkg.sv @@
// Package for the sparse polynomial multiply unit: item types, sizes, FSM states.
// No dependencies.
package spm_pkg;
	localparam int MAX_TERMS_FIRST  = 8;
	localparam int MAX_TERMS_SECOND = 8;
	localparam int COEF_BITS        = 16;
	localparam int EXP_BITS         = 16;
	localparam int PROD_DEPTH       = 64;
	localparam int PCOEF_W          = 38;
	localparam int PEXP_W           = 17;
	localparam int PADDR_W          = $clog2(PROD_DEPTH);
	localparam int PCNT_W           = $clog2(PROD_DEPTH + 1);
	localparam int FIDX_W           = $clog2(MAX_TERMS_FIRST) > 0 ? $clog2(MAX_TERMS_FIRST) : 1;
	localparam int SIDX_W           = $clog2(MAX_TERMS_SECOND) > 0 ? $clog2(MAX_TERMS_SECOND) : 1;
	localparam int FCNT_W           = $clog2(MAX_TERMS_FIRST + 1);
	localparam int SCNT_W           = $clog2(MAX_TERMS_SECOND + 1);

	localparam logic [1:0] REQ_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] REQ_LOAD_SECOND = 2'd1;
	localparam logic [1:0] REQ_GO          = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] term_coef_in;
		logic [15:0]        term_exp_in;
	} cmd_t;

	typedef struct packed {
		logic signed [PCOEF_W-1:0] prod_coef;
		logic [PEXP_W-1:0]         prod_exp;
		logic                      term_valid;
		logic [6:0]                term_total;
		logic                      load_overflow;
		logic                      last_term;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAIR, ST_SCAN, ST_SCAN_CHK, ST_CNT, ST_CNT_CHK, ST_FIND, ST_FIND_CHK
	} state_t;
endpackage

@@ rtl/sparse_polynomial_multiply_unit.sv @@
// Top level of the sparse polynomial multiply unit: operand stores, product memory, sequencer.
// Depends on spm_pkg and sparse_polynomial_multiply_unit_macros.svh.
//
// channel   direction  handshake                  payload
// command   in         start & !busy              cmd  (spm_pkg::cmd_t)
// result    out        rsp_strobe, one cycle      rsp  (spm_pkg::rsp_t)
//
// Loads leave busy low. A go item holds busy high while the
// sequencer walks the product memory (one port, registered read): each pair
// is multiplied and the stored entries are scanned for its exponent, which is
// summed into a like term or appended; then the nonzero entries are counted,
// and a full scan of the memory finds each emitted term in turn.
// Reset clears the counts, the status flag and the sequencer; memories are not
// cleared, entries are read only below the fill count. Results are strobed and
// cannot be stalled.
`include "sparse_polynomial_multiply_unit_macros.svh"
module sparse_polynomial_multiply_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spm_pkg::cmd_t cmd,
	output logic          rsp_strobe,
	output spm_pkg::rsp_t rsp
);
	import spm_pkg::*;

	// operand stores, each read at one sequencer-chosen index
	logic signed [COEF_BITS-1:0] a_coef_q [MAX_TERMS_FIRST];
	logic [EXP_BITS-1:0]         a_exp_q  [MAX_TERMS_FIRST];
	logic signed [COEF_BITS-1:0] b_coef_q [MAX_TERMS_SECOND];
	logic [EXP_BITS-1:0]         b_exp_q  [MAX_TERMS_SECOND];

	// product memory
	logic signed [PCOEF_W-1:0] pm_coef [PROD_DEPTH];
	logic [PEXP_W-1:0]         pm_exp  [PROD_DEPTH];
	logic signed [PCOEF_W-1:0] rd_coef_q;
	logic [PEXP_W-1:0]         rd_exp_q;
	logic                      mem_we;
	logic [PADDR_W-1:0]        mem_waddr;
	logic signed [PCOEF_W-1:0] mem_wcoef;
	logic [PEXP_W-1:0]         mem_wexp;

	state_t state_q, state_d;
	logic [FCNT_W-1:0] fcnt_q, fcnt_d;
	logic [SCNT_W-1:0] scnt_q, scnt_d;
	logic              ovf_q, ovf_d;
	logic [FIDX_W-1:0] i_q, i_d;
	logic [SIDX_W-1:0] j_q, j_d;
	logic [PCNT_W-1:0] pcnt_q, pcnt_d;   // filled product entries
	logic [PCNT_W-1:0] k_q, k_d;         // scan pointer
	logic [PCNT_W-1:0] total_q, total_d; // nonzero terms
	logic [PCNT_W-1:0] sent_q, sent_d;   // terms emitted
	logic              bound_ok_q, bound_ok_d;
	logic [PEXP_W-1:0] bound_q, bound_d;
	logic              best_ok_q, best_ok_d;
	logic signed [PCOEF_W-1:0] best_coef_q, best_coef_d;
	logic [PEXP_W-1:0] best_exp_q, best_exp_d;
	logic signed [PCOEF_W-1:0] pc_q, pc_d;
	logic [PEXP_W-1:0] pe_q, pe_d;
	logic              strobe_d;
	rsp_t              rsp_d;

	logic signed [COEF_BITS-1:0] cin;
	logic [EXP_BITS-1:0]         ein;
	logic signed [2*COEF_BITS-1:0] mul;
	logic                        take;
	logic                        last_pair;
	logic                        cand;

	assign cin  = cmd.term_coef_in[COEF_BITS-1:0];
	assign ein  = cmd.term_exp_in[EXP_BITS-1:0];
	assign take = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign mul  = a_coef_q[i_q] * b_coef_q[j_q];
	assign last_pair = ({1'b0, i_q} == FCNT_W'(fcnt_q - 1'b1)) &&
		({1'b0, j_q} == SCNT_W'(scnt_q - 1'b1));
	assign cand = (rd_coef_q != '0) && (!bound_ok_q || rd_exp_q < bound_q) &&
		(!best_ok_q || rd_exp_q > best_exp_q);

	always_comb begin
		state_d     = state_q;
		fcnt_d      = fcnt_q;
		scnt_d      = scnt_q;
		ovf_d       = ovf_q;
		i_d         = i_q;
		j_d         = j_q;
		pcnt_d      = pcnt_q;
		k_d         = k_q;
		total_d     = total_q;
		sent_d      = sent_q;
		bound_ok_d  = bound_ok_q;
		bound_d     = bound_q;
		best_ok_d   = best_ok_q;
		best_coef_d = best_coef_q;
		best_exp_d  = best_exp_q;
		pc_d        = pc_q;
		pe_d        = pe_q;
		strobe_d    = 1'b0;
		rsp_d       = rsp;
		mem_we      = 1'b0;
		mem_waddr   = k_q[PADDR_W-1:0];
		mem_wcoef   = pc_q;
		mem_wexp    = pe_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (cmd.req_type)
						REQ_LOAD_FIRST: begin
							if (fcnt_q < FCNT_W'(MAX_TERMS_FIRST)) fcnt_d = fcnt_q + 1'b1;
							else ovf_d = 1'b1;
						end
						REQ_LOAD_SECOND: begin
							if (scnt_q < SCNT_W'(MAX_TERMS_SECOND)) scnt_d = scnt_q + 1'b1;
							else ovf_d = 1'b1;
						end
						REQ_GO: begin
							i_d = '0;
							j_d = '0;
							pcnt_d = '0;
							k_d = '0;
							total_d = '0;
							state_d = (fcnt_q == '0 || scnt_q == '0) ? ST_CNT : ST_PAIR;
						end
						default: ;
					endcase
				end
			end
			ST_PAIR: begin
				pc_d = PCOEF_W'(mul);
				pe_d = PEXP_W'({1'b0, a_exp_q[i_q]} + {1'b0, b_exp_q[j_q]});
				k_d = '0;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (k_q == pcnt_q) begin
					// no like term: append
					mem_we = 1'b1;
					mem_waddr = pcnt_q[PADDR_W-1:0];
					pcnt_d = pcnt_q + 1'b1;
					state_d = ST_PAIR;
					if (last_pair) begin
						k_d = '0;
						state_d = ST_CNT;
					end else if ({1'b0, i_q} == FCNT_W'(fcnt_q - 1'b1)) begin
						i_d = '0;
						j_d = j_q + 1'b1;
					end else begin
						i_d = i_q + 1'b1;
					end
				end else begin
					state_d = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				if (rd_exp_q == pe_q) begin
					mem_we = 1'b1;
					mem_wcoef = rd_coef_q + pc_q;
					state_d = ST_PAIR;
					if (last_pair) begin
						k_d = '0;
						state_d = ST_CNT;
					end else if ({1'b0, i_q} == FCNT_W'(fcnt_q - 1'b1)) begin
						i_d = '0;
						j_d = j_q + 1'b1;
					end else begin
						i_d = i_q + 1'b1;
					end
				end else begin
					k_d = k_q + 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_CNT: begin
				if (k_q == pcnt_q) begin
					k_d = '0;
					sent_d = '0;
					bound_ok_d = 1'b0;
					best_ok_d = 1'b0;
					if (total_q == '0) begin
						// empty product: one invalid item
						strobe_d = 1'b1;
						rsp_d.prod_coef = '0;
						rsp_d.prod_exp = '0;
						rsp_d.term_valid = 1'b0;
						rsp_d.term_total = '0;
						rsp_d.load_overflow = ovf_q;
						rsp_d.last_term = 1'b1;
						fcnt_d = '0;
						scnt_d = '0;
						ovf_d = 1'b0;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_FIND;
					end
				end else begin
					state_d = ST_CNT_CHK;
				end
			end
			ST_CNT_CHK: begin
				if (rd_coef_q != '0) total_d = total_q + 1'b1;
				k_d = k_q + 1'b1;
				state_d = ST_CNT;
			end
			ST_FIND: begin
				state_d = ST_FIND_CHK;
			end
			ST_FIND_CHK: begin
				if (cand) begin
					best_ok_d = 1'b1;
					best_coef_d = rd_coef_q;
					best_exp_d = rd_exp_q;
				end
				if (k_q + 1'b1 == pcnt_q) begin
					// scan done: emit the largest exponent below the bound
					strobe_d = 1'b1;
					rsp_d.prod_coef = cand ? rd_coef_q : best_coef_q;
					rsp_d.prod_exp = cand ? rd_exp_q : best_exp_q;
					rsp_d.term_valid = 1'b1;
					rsp_d.term_total = 7'(total_q);
					rsp_d.load_overflow = ovf_q;
					rsp_d.last_term = (sent_q + 1'b1 == total_q);
					bound_ok_d = 1'b1;
					bound_d = cand ? rd_exp_q : best_exp_q;
					best_ok_d = 1'b0;
					sent_d = sent_q + 1'b1;
					k_d = '0;
					if (sent_q + 1'b1 == total_q) begin
						fcnt_d = '0;
						scnt_d = '0;
						ovf_d = 1'b0;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_FIND;
					end
				end else begin
					k_d = k_q + 1'b1;
					state_d = ST_FIND;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fcnt_q     <= '0;
			scnt_q     <= '0;
			ovf_q      <= 1'b0;
			rsp_strobe <= 1'b0;
		end else begin
			state_q    <= state_d;
			fcnt_q     <= fcnt_d;
			scnt_q     <= scnt_d;
			ovf_q      <= ovf_d;
			rsp_strobe <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q         <= i_d;
		j_q         <= j_d;
		pcnt_q      <= pcnt_d;
		k_q         <= k_d;
		total_q     <= total_d;
		sent_q      <= sent_d;
		bound_ok_q  <= bound_ok_d;
		bound_q     <= bound_d;
		best_ok_q   <= best_ok_d;
		best_coef_q <= best_coef_d;
		best_exp_q  <= best_exp_d;
		pc_q        <= pc_d;
		pe_q        <= pe_d;
		rsp         <= rsp_d;
	end

	// operand store writes
	always_ff @(posedge clk) begin
		if (take && cmd.req_type == REQ_LOAD_FIRST && fcnt_q < FCNT_W'(MAX_TERMS_FIRST)) begin
			a_coef_q[fcnt_q[FIDX_W-1:0]] <= cin;
			a_exp_q[fcnt_q[FIDX_W-1:0]]  <= ein;
		end
		if (take && cmd.req_type == REQ_LOAD_SECOND && scnt_q < SCNT_W'(MAX_TERMS_SECOND)) begin
			b_coef_q[scnt_q[SIDX_W-1:0]] <= cin;
			b_exp_q[scnt_q[SIDX_W-1:0]]  <= ein;
		end
	end

	// product memory, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pm_coef[mem_waddr] <= mem_wcoef;
			pm_exp[mem_waddr]  <= mem_wexp;
		end
		rd_coef_q <= pm_coef[k_q[PADDR_W-1:0]];
		rd_exp_q  <= pm_exp[k_q[PADDR_W-1:0]];
	end

	`SPM_ASSERT_ALWAYS(a_pcnt_range, pcnt_q <= PCNT_W'(PROD_DEPTH) || state_q == ST_IDLE)
	`SPM_ASSERT_IMPLY(a_empty_is_last, rsp_strobe && !rsp.term_valid, rsp.last_term)
	`SPM_ASSERT_IMPLY(a_last_frees, rsp_strobe && rsp.last_term, !busy)
	`SPM_ASSERT_NEXT(a_go_busy, take && cmd.req_type == REQ_GO, busy)
	`SPM_ASSERT_IMPLY(a_sent_bound, state_q == ST_FIND_CHK, sent_q < total_q)
endmodule

@@ tb/spm_checker.sv @@
// Result checker for the sparse polynomial multiply unit: watches the command and result
// channels, predicts every product term and compares. Depends on spm_pkg.
module spm_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  spm_pkg::cmd_t cmd,
	input  logic          rsp_strobe,
	input  spm_pkg::rsp_t rsp,
	output int            fail_count,
	output int            terms_pending,
	output int            products_seen,
	output int            terms_seen
);
	import spm_pkg::*;

	longint  a_coef[MAX_TERMS_FIRST];
	longint  a_exp[MAX_TERMS_FIRST];
	longint  b_coef[MAX_TERMS_SECOND];
	longint  b_exp[MAX_TERMS_SECOND];
	int      a_count, b_count;
	bit      lost_load;
	rsp_t    expected_terms[$];

	assign terms_pending = expected_terms.size();

	// multiply the loaded operands and queue the emitted terms
	task automatic multiply_operands();
		longint pc[PROD_DEPTH];
		longint pe[PROD_DEPTH];
		int     n, total, k, pos;
		longint c, e;
		rsp_t   r;
		n = 0;
		for (int j = 0; j < b_count; j++)
			for (int i = 0; i < a_count; i++) begin
				c = a_coef[i] * b_coef[j];
				e = a_exp[i] + b_exp[j];
				pos = 0;
				while (pos < n && pe[pos] > e)
					pos++;
				if (pos < n && pe[pos] == e)
					pc[pos] += c;
				else if (n < PROD_DEPTH) begin
					for (int m = n; m > pos; m--) begin
						pc[m] = pc[m-1];
						pe[m] = pe[m-1];
					end
					pc[pos] = c;
					pe[pos] = e;
					n++;
				end
			end
		total = 0;
		for (int i = 0; i < n; i++)
			if (pc[i] != 0)
				total++;
		if (total == 0) begin
			r = '0;
			r.load_overflow = lost_load;
			r.last_term = 1'b1;
			expected_terms.push_back(r);
		end else begin
			k = 0;
			for (int i = 0; i < n; i++) begin
				if (pc[i] == 0)
					continue;
				r.prod_coef = pc[i][PCOEF_W-1:0];
				r.prod_exp = pe[i][PEXP_W-1:0];
				r.term_valid = 1'b1;
				r.term_total = total[6:0];
				r.load_overflow = lost_load;
				r.last_term = (k + 1 == total);
				expected_terms.push_back(r);
				k++;
			end
		end
		a_count = 0;
		b_count = 0;
		lost_load = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			a_count = 0;
			b_count = 0;
			lost_load = 1'b0;
			fail_count = 0;
			products_seen = 0;
			terms_seen = 0;
			expected_terms.delete();
		end else begin
			if (start && !busy) begin
				case (cmd.req_type)
				REQ_LOAD_FIRST: begin
					if (a_count < MAX_TERMS_FIRST) begin
						a_coef[a_count] = longint'(cmd.term_coef_in);
						a_exp[a_count] = longint'({1'b0, cmd.term_exp_in});
						a_count++;
					end else
						lost_load = 1'b1;
				end
				REQ_LOAD_SECOND: begin
					if (b_count < MAX_TERMS_SECOND) begin
						b_coef[b_count] = longint'(cmd.term_coef_in);
						b_exp[b_count] = longint'({1'b0, cmd.term_exp_in});
						b_count++;
					end else
						lost_load = 1'b1;
				end
				REQ_GO: begin
					multiply_operands();
					products_seen++;
				end
				default: ;
				endcase
			end
			if (rsp_strobe) begin
				terms_seen++;
				if (expected_terms.size() == 0) begin
					$error("unexpected result item: coef %0d exp %0d", rsp.prod_coef,
						rsp.prod_exp);
					fail_count++;
				end else begin
					want = expected_terms.pop_front();
					if (rsp.prod_coef !== want.prod_coef) begin
						$error("prod_coef: expected %0d, got %0d", want.prod_coef,
							rsp.prod_coef);
						fail_count++;
					end
					if (rsp.prod_exp !== want.prod_exp) begin
						$error("prod_exp: expected %0d, got %0d", want.prod_exp, rsp.prod_exp);
						fail_count++;
					end
					if (rsp.term_valid !== want.term_valid) begin
						$error("term_valid: expected %0d, got %0d", want.term_valid,
							rsp.term_valid);
						fail_count++;
					end
					if (rsp.term_total !== want.term_total) begin
						$error("term_total: expected %0d, got %0d", want.term_total,
							rsp.term_total);
						fail_count++;
					end
					if (rsp.load_overflow !== want.load_overflow) begin
						$error("load_overflow: expected %0d, got %0d", want.load_overflow,
							rsp.load_overflow);
						fail_count++;
					end
					if (rsp.last_term !== want.last_term) begin
						$error("last_term: expected %0d, got %0d", want.last_term,
							rsp.last_term);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

@@ tb/tb_sparse_polynomial_multiply_unit.sv @@
// Testbench top for the sparse polynomial multiply unit: clock, reset, command stimulus
// and verdict. Depends on spm_pkg, the unit's RTL and spm_checker.
module tb_sparse_polynomial_multiply_unit;
	import spm_pkg::*;

	localparam int RUN_LIMIT = 3000000;  // cycles

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_t cmd = '0;
	logic rsp_strobe;
	rsp_t rsp;
	int   fail_count, terms_pending, products_seen, terms_seen;
	int   items_sent = 0;
	int   cycle_count = 0;
	int   gap_pct = 17;

	always #6 clk = ~clk;

	sparse_polynomial_multiply_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .rsp_strobe(rsp_strobe), .rsp(rsp)
	);

	spm_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.rsp_strobe(rsp_strobe), .rsp(rsp), .fail_count(fail_count),
		.terms_pending(terms_pending), .products_seen(products_seen),
		.terms_seen(terms_seen)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// present one item and hold it until the unit takes it; start stays high afterwards
	// so back-to-back items never drop it, and an idle gap lowers it before the item
	task automatic send_item(input logic [1:0] req, input logic [15:0] coef,
		input logic [15:0] exps);
		cmd_t c;
		c.req_type = req;
		c.term_coef_in = coef;
		c.term_exp_in = exps;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		items_sent++;
		// sender idling follows the phase of the run
		if (items_sent == 100)
			gap_pct = 63;
		else if (items_sent == 200)
			gap_pct = 0;
	endtask

	// hold the command channel quiet until every queued term has come out
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (terms_pending != 0 || busy)
			@(posedge clk);
	endtask

	// random coefficient: small so products cancel and merge, the extremes, or full range
	function automatic logic [15:0] pick_coef();
		case ($urandom_range(3))
		0: return 16'($signed($urandom_range(6)) - 3);
		1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_exp(input bit narrow);
		if (narrow)
			return 16'($urandom_range(7));
		return $urandom_range(3) == 0 ? ($urandom_range(1) ? 16'hFFFF : 16'h0) : 16'($urandom);
	endfunction

	initial begin
		int na, nb;
		bit narrow;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty product, both sides empty
		send_item(REQ_GO, 16'h0, 16'h0);
		// extremes of coefficient and exponent
		send_item(REQ_LOAD_FIRST, 16'h8000, 16'hFFFF);
		send_item(REQ_LOAD_FIRST, 16'h7FFF, 16'h0000);
		send_item(REQ_LOAD_SECOND, 16'h8000, 16'hFFFF);
		send_item(REQ_LOAD_SECOND, 16'hFFFF, 16'h0000);
		send_item(REQ_GO, 16'h0, 16'h0);
		// cancellation: (x + 1)(x - 1), loaded in ascending order, plus an unknown request
		send_item(REQ_LOAD_FIRST, 16'd1, 16'd0);
		send_item(REQ_LOAD_FIRST, 16'd1, 16'd1);
		send_item(2'd3, 16'h5A5A, 16'hA5A5);
		send_item(REQ_LOAD_SECOND, 16'hFFFF, 16'd0);
		send_item(REQ_LOAD_SECOND, 16'd1, 16'd1);
		send_item(REQ_GO, 16'h0, 16'h0);
		// only the first operand loaded, with a zero term
		send_item(REQ_LOAD_FIRST, 16'd0, 16'd3);
		send_item(REQ_LOAD_FIRST, 16'd5, 16'd2);
		send_item(REQ_GO, 16'h0, 16'h0);
		// overflow on both stores
		for (int i = 0; i < 9; i++) begin
			send_item(REQ_LOAD_FIRST, 16'(i + 1), 16'(20 - i));
			send_item(REQ_LOAD_SECOND, 16'(i - 4), 16'(i));
		end
		send_item(REQ_GO, 16'h0, 16'h0);
		drain();

		// random operand sets, each closed by a go; some broken by noise or overflow
		while (items_sent < 300) begin
			na = $urandom_range(9) == 0 ? $urandom_range(9, 10) : $urandom_range(8);
			nb = $urandom_range(9) == 0 ? $urandom_range(9, 10) : $urandom_range(8);
			narrow = $urandom_range(1);
			for (int i = 0; i < na + nb; i++) begin
				if ($urandom_range(15) == 0)
					send_item(2'd3, 16'($urandom), 16'($urandom));
				if ((i < na) ^ ($urandom_range(3) == 0 && i >= na))
					send_item(REQ_LOAD_FIRST, pick_coef(), pick_exp(narrow));
				else
					send_item(REQ_LOAD_SECOND, pick_coef(), pick_exp(narrow));
			end
			send_item(REQ_GO, 16'($urandom), 16'($urandom));
			if ($urandom_range(7) == 0)
				drain();
		end
		drain();
		repeat (50) @(posedge clk);

		$display("Covered %0d items and %0d products, %0d result terms checked.",
			items_sent, products_seen, terms_seen);
		$display("Included loads past capacity, cancellation, empty products and idle gaps.");
		if (fail_count == 0 && terms_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
